// ===== design/jts_pkg.sv =====
package jts_pkg;

  localparam int CHAR_BITS = 21;
  localparam int COL_BITS  = 16;
  localparam int ROW_BITS  = 32;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  typedef logic [CHAR_BITS-1:0] char_t;
  typedef logic [COL_BITS-1:0]  col_t;
  typedef logic [ROW_BITS-1:0]  row_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_LITERAL,
    MODE_NUMBER
  } mode_t;

  typedef enum logic [3:0] {
    TK_LBRACKET,
    TK_RBRACKET,
    TK_LBRACE,
    TK_RBRACE,
    TK_COMMA,
    TK_COLON,
    TK_STRING,
    TK_NUMBER,
    TK_NULL,
    TK_TRUE,
    TK_FALSE,
    TK_INVALID,
    TK_EOF
  } tok_kind_t;

  // classified character as it travels through the queue
  typedef struct packed {
    logic      eos;
    logic      nl;
    logic      quote;
    logic      bslash;
    logic      punct;
    tok_kind_t pkind;
    logic      alpha;
    logic      digit;
    logic      minus;
    logic      numch;
    logic [3:0] kn_hit;
    logic [3:0] kt_hit;
    logic [4:0] kf_hit;
  } class_t;

  typedef struct packed {
    tok_kind_t kind;
    col_t      sc;
    row_t      sr;
    col_t      ec;
    logic      last;
  } tok_t;

endpackage

// ===== design/jts_front.sv =====
module jts_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  jts_pkg::char_t       in_character,
  input  logic                 in_end_of_stream,
  input  logic                 q_full,
  output logic                 q_push,
  output jts_pkg::class_t      q_din
);

  localparam jts_pkg::char_t CH_LF       = jts_pkg::char_t'(8'h0a);
  localparam jts_pkg::char_t CH_CR       = jts_pkg::char_t'(8'h0d);
  localparam jts_pkg::char_t CH_QUOTE    = jts_pkg::char_t'(8'h22);
  localparam jts_pkg::char_t CH_BSLASH   = jts_pkg::char_t'(8'h5c);
  localparam jts_pkg::char_t CH_LBRACKET = jts_pkg::char_t'(8'h5b);
  localparam jts_pkg::char_t CH_RBRACKET = jts_pkg::char_t'(8'h5d);
  localparam jts_pkg::char_t CH_LBRACE   = jts_pkg::char_t'(8'h7b);
  localparam jts_pkg::char_t CH_RBRACE   = jts_pkg::char_t'(8'h7d);
  localparam jts_pkg::char_t CH_COMMA    = jts_pkg::char_t'(8'h2c);
  localparam jts_pkg::char_t CH_COLON    = jts_pkg::char_t'(8'h3a);
  localparam jts_pkg::char_t CH_MINUS    = jts_pkg::char_t'(8'h2d);
  localparam jts_pkg::char_t CH_DOT      = jts_pkg::char_t'(8'h2e);
  localparam jts_pkg::char_t CH_LOW_E    = jts_pkg::char_t'(8'h65);
  localparam jts_pkg::char_t CH_UP_E     = jts_pkg::char_t'(8'h45);

  localparam logic [7:0] KW_NULL  [4] = '{8'h6e, 8'h75, 8'h6c, 8'h6c};
  localparam logic [7:0] KW_TRUE  [4] = '{8'h74, 8'h72, 8'h75, 8'h65};
  localparam logic [7:0] KW_FALSE [5] = '{8'h66, 8'h61, 8'h6c, 8'h73, 8'h65};

  jts_pkg::char_t c;

  assign c        = in_character;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_din        = '0;
    q_din.eos    = in_end_of_stream;
    q_din.nl     = (c == CH_LF) || (c == CH_CR);
    q_din.quote  = (c == CH_QUOTE);
    q_din.bslash = (c == CH_BSLASH);
    q_din.alpha  = ((c >= jts_pkg::char_t'(8'h61)) && (c <= jts_pkg::char_t'(8'h7a))) ||
                   ((c >= jts_pkg::char_t'(8'h41)) && (c <= jts_pkg::char_t'(8'h5a)));
    q_din.digit  = (c >= jts_pkg::char_t'(8'h30)) && (c <= jts_pkg::char_t'(8'h39));
    q_din.minus  = (c == CH_MINUS);
    q_din.numch  = q_din.digit || (c == CH_MINUS) || (c == CH_LOW_E) ||
                   (c == CH_UP_E) || (c == CH_DOT);
    q_din.punct  = 1'b1;
    case (c)
      CH_LBRACKET: q_din.pkind = jts_pkg::TK_LBRACKET;
      CH_RBRACKET: q_din.pkind = jts_pkg::TK_RBRACKET;
      CH_LBRACE:   q_din.pkind = jts_pkg::TK_LBRACE;
      CH_RBRACE:   q_din.pkind = jts_pkg::TK_RBRACE;
      CH_COMMA:    q_din.pkind = jts_pkg::TK_COMMA;
      CH_COLON:    q_din.pkind = jts_pkg::TK_COLON;
      default: begin
        q_din.pkind = jts_pkg::TK_INVALID;
        q_din.punct = 1'b0;
      end
    endcase
    // keyword letter hits per position, looked up by progress in the back end
    for (int i = 0; i < 4; i++) begin
      q_din.kn_hit[i] = (c == jts_pkg::char_t'(KW_NULL[i]));
      q_din.kt_hit[i] = (c == jts_pkg::char_t'(KW_TRUE[i]));
    end
    for (int i = 0; i < 5; i++) begin
      q_din.kf_hit[i] = (c == jts_pkg::char_t'(KW_FALSE[i]));
    end
  end

endmodule

// ===== design/jts_queue.sv =====
module jts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jts_pkg::class_t din,
  input  logic            pop,
  output jts_pkg::class_t dout,
  output logic            empty,
  output logic            full
);

  jts_pkg::class_t             mem_r [jts_pkg::Q_DEPTH];
  logic [jts_pkg::Q_AW-1:0]    wp_r, wp_nxt;
  logic [jts_pkg::Q_AW-1:0]    rp_r, rp_nxt;
  logic [jts_pkg::Q_AW:0]      cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (jts_pkg::Q_AW+1)'(jts_pkg::Q_DEPTH));
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ===== design/jts_back.sv =====
module jts_back (
  input  logic            clk,
  input  logic            rst_n,
  input  jts_pkg::class_t q_dout,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output jts_pkg::tok_t   out_tok
);

  jts_pkg::mode_t mode_r, mode_nxt;
  logic           esc_r, esc_nxt;
  logic           done_r, done_nxt;
  jts_pkg::row_t  row_r, row_nxt;
  jts_pkg::col_t  ncol_r, ncol_nxt;
  jts_pkg::col_t  tsc_r, tsc_nxt;
  jts_pkg::row_t  tsr_r, tsr_nxt;
  jts_pkg::col_t  tec_r, tec_nxt;
  logic [2:0]     kwp_r, kwp_nxt;
  logic [2:0]     kwc_r, kwc_nxt;

  logic           out_v_r, hold_v_r;
  jts_pkg::tok_t  out_r, hold_r;

  jts_pkg::class_t cl;
  logic           adv;
  logic           is_str, is_lit, is_num;
  logic           ends_run, scan_idle, str_close, str_nl;
  jts_pkg::col_t  colp1;
  jts_pkg::row_t  row_n;
  jts_pkg::tok_kind_t lit_kind, pend_kind;
  jts_pkg::tok_t  pend_tok, eof_tok, punct_tok;
  jts_pkg::tok_t  r0, r1;
  logic           r0_v, r1_v;
  logic [5:0]     feed_cont, feed_new;

  function automatic jts_pkg::col_t col_inc(input jts_pkg::col_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic jts_pkg::row_t row_inc(input jts_pkg::row_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // returns {progress, candidates} after one more letter
  function automatic logic [5:0] kw_feed(input logic [2:0] p, input logic [2:0] cands,
                                         input jts_pkg::class_t k);
    logic nb, tb, fb;
    logic [2:0] pn;
    logic [7:0] kf_ext;
    kf_ext = {3'b000, k.kf_hit};
    nb = (p < 3'd4) && k.kn_hit[p[1:0]];
    tb = (p < 3'd4) && k.kt_hit[p[1:0]];
    fb = kf_ext[p];
    pn = (p == 3'd7) ? p : p + 1'b1;
    return {pn, cands & {fb, tb, nb}};
  endfunction

  assign cl        = q_dout;
  assign adv       = !out_v_r || !out_stall;
  assign q_pop     = adv && !hold_v_r && !q_empty;
  assign out_valid = out_v_r;
  assign out_tok   = out_r;

  assign is_str    = (mode_r == jts_pkg::MODE_STRING);
  assign is_lit    = (mode_r == jts_pkg::MODE_LITERAL);
  assign is_num    = (mode_r == jts_pkg::MODE_NUMBER);
  assign ends_run  = (is_lit && !(cl.alpha || cl.digit)) || (is_num && !cl.numch);
  assign scan_idle = (mode_r == jts_pkg::MODE_IDLE) || ends_run;
  assign str_nl    = is_str && cl.nl;
  // the character is ignored on an end-of-stream beat
  assign str_close = is_str && !cl.eos && !cl.nl && cl.quote && !esc_r;
  assign colp1     = col_inc(ncol_r);
  assign row_n     = cl.nl ? row_inc(row_r) : row_r;
  assign feed_cont = kw_feed(kwp_r, kwc_r, cl);
  assign feed_new  = kw_feed(3'd0, 3'b111, cl);

  always_comb begin
    if (kwc_r[0] && (kwp_r == 3'd4)) begin
      lit_kind = jts_pkg::TK_NULL;
    end else if (kwc_r[1] && (kwp_r == 3'd4)) begin
      lit_kind = jts_pkg::TK_TRUE;
    end else if (kwc_r[2] && (kwp_r == 3'd5)) begin
      lit_kind = jts_pkg::TK_FALSE;
    end else begin
      lit_kind = jts_pkg::TK_INVALID;
    end
    case (mode_r)
      jts_pkg::MODE_NUMBER:  pend_kind = jts_pkg::TK_NUMBER;
      jts_pkg::MODE_LITERAL: pend_kind = lit_kind;
      default:               pend_kind = jts_pkg::TK_STRING;
    endcase
  end

  always_comb begin
    pend_tok      = '{kind: pend_kind, sc: tsc_r, sr: tsr_r, ec: tec_r, last: 1'b0};
    // closing quote belongs to the string
    if (str_close) begin
      pend_tok.ec = colp1;
    end
    eof_tok   = '{kind: jts_pkg::TK_EOF, sc: '0, sr: row_inc(row_r), ec: '0, last: 1'b0};
    punct_tok = '{kind: cl.pkind, sc: ncol_r, sr: row_n, ec: colp1, last: 1'b0};
  end

  // next state of the scanner
  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    done_nxt = done_r;
    row_nxt  = row_r;
    ncol_nxt = ncol_r;
    tsc_nxt  = tsc_r;
    tsr_nxt  = tsr_r;
    tec_nxt  = tec_r;
    kwp_nxt  = kwp_r;
    kwc_nxt  = kwc_r;
    if (q_pop && !done_r) begin
      if (cl.eos) begin
        mode_nxt = jts_pkg::MODE_IDLE;
        done_nxt = 1'b1;
      end else begin
        row_nxt  = row_n;
        ncol_nxt = cl.nl ? '0 : colp1;
        if (is_str) begin
          if (str_nl) begin
            mode_nxt = jts_pkg::MODE_IDLE;
          end else if (str_close) begin
            tec_nxt  = colp1;
            mode_nxt = jts_pkg::MODE_IDLE;
          end else begin
            esc_nxt = cl.bslash ? !esc_r : 1'b0;
            tec_nxt = colp1;
          end
        end else begin
          if (is_lit && (cl.alpha || cl.digit)) begin
            {kwp_nxt, kwc_nxt} = feed_cont;
            tec_nxt = colp1;
          end
          if (is_num && cl.numch) begin
            tec_nxt = colp1;
          end
          if (scan_idle) begin
            tsc_nxt  = ncol_r;
            tsr_nxt  = row_n;
            tec_nxt  = colp1;
            mode_nxt = jts_pkg::MODE_IDLE;
            if (cl.punct) begin
              mode_nxt = jts_pkg::MODE_IDLE;
            end else if (cl.quote) begin
              mode_nxt = jts_pkg::MODE_STRING;
              esc_nxt  = 1'b0;
            end else if (cl.alpha) begin
              mode_nxt = jts_pkg::MODE_LITERAL;
              {kwp_nxt, kwc_nxt} = feed_new;
            end else if (cl.digit || cl.minus) begin
              mode_nxt = jts_pkg::MODE_NUMBER;
            end
          end
        end
      end
    end
  end

  // tokens caused by the beat being processed
  always_comb begin
    r0   = eof_tok;
    r1   = eof_tok;
    r0_v = 1'b0;
    r1_v = 1'b0;
    if (done_r) begin
      r0_v = 1'b1;
    end else if (cl.eos) begin
      r0_v = 1'b1;
      if (mode_r != jts_pkg::MODE_IDLE) begin
        r0   = pend_tok;
        r1_v = 1'b1;
      end
    end else if (is_str) begin
      if (str_nl || str_close) begin
        r0   = pend_tok;
        r0_v = 1'b1;
      end
    end else begin
      if (ends_run) begin
        r0   = pend_tok;
        r0_v = 1'b1;
      end
      if (scan_idle && cl.punct) begin
        if (ends_run) begin
          r1   = punct_tok;
          r1_v = 1'b1;
        end else begin
          r0   = punct_tok;
          r0_v = 1'b1;
        end
      end
    end
    r0.last = !r1_v;
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= jts_pkg::MODE_IDLE;
      esc_r    <= 1'b0;
      done_r   <= 1'b0;
      row_r    <= '0;
      ncol_r   <= '0;
      tsc_r    <= '0;
      tsr_r    <= '0;
      tec_r    <= '0;
      kwp_r    <= '0;
      kwc_r    <= 3'b111;
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      done_r <= done_nxt;
      row_r  <= row_nxt;
      ncol_r <= ncol_nxt;
      tsc_r  <= tsc_nxt;
      tsr_r  <= tsr_nxt;
      tec_r  <= tec_nxt;
      kwp_r  <= kwp_nxt;
      kwc_r  <= kwc_nxt;
      if (adv) begin
        if (hold_v_r) begin
          out_v_r  <= 1'b1;
          hold_v_r <= 1'b0;
        end else if (q_pop) begin
          out_v_r  <= r0_v;
          hold_v_r <= r1_v;
        end else begin
          out_v_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (hold_v_r) begin
        out_r <= hold_r;
      end else if (q_pop) begin
        out_r  <= r0;
        hold_r <= r1;
      end
    end
  end

`ifndef SYNTHESIS
  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> out_v_r)
    else $error("second token held without a first one on the output");

  a_hold_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> hold_r.last)
    else $error("held second token not marked last");

  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_r.kind == jts_pkg::TK_EOF)) |-> out_r.last)
    else $error("eof token not marked last");

  a_done_gives_eof: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> ((out_v_r && (out_r.kind == jts_pkg::TK_EOF)) ||
                       (hold_v_r && (hold_r.kind == jts_pkg::TK_EOF))))
    else $error("end of stream taken without an eof token");
`endif

endmodule

// ===== design/json_token_scanner_unit.sv =====
// channel | direction | handshake          | beat payload
// in_     | input     | in_valid/in_stall   | character, end_of_stream
// out_    | output    | out_valid/out_stall | token kind, start/end column and row, last
//
// one character per cycle enters a four-deep queue unless it is full; the back
// end retires one queued character per cycle unless out_stall holds it; after one
// that yields two tokens it waits while the single output register delivers both
// in turn; a character waits in the queue, then its token in the output register
// reset is synchronous, empties the queue, clears the scanner state and the output valid flags
// in_stall rises only when the queue is full; out_stall holds the output token
module json_token_scanner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [20:0] in_character,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_start_column,
  output logic [31:0] out_start_row,
  output logic [15:0] out_end_column,
  output logic [31:0] out_end_row,
  output logic        out_last_of_run
);

  logic            q_push, q_pop, q_empty, q_full;
  jts_pkg::class_t q_din, q_dout;
  jts_pkg::tok_t   tok;

  jts_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_character     (jts_pkg::char_t'(in_character)),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_din            (q_din)
  );

  jts_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  jts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_dout    (q_dout),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tok   (tok)
  );

  assign out_token_kind   = 4'(tok.kind);
  assign out_start_column = 16'(tok.sc);
  assign out_start_row    = 32'(tok.sr);
  assign out_end_column   = 16'(tok.ec);
  assign out_end_row      = 32'(tok.sr);
  assign out_last_of_run  = tok.last;

endmodule
